FILE: rtl/dfs_pkg.sv
// Shared types, constants and state codes of the DMX512 frame sequencer.
`default_nettype none

package dfs_pkg;

    localparam int SLOT_COUNT = 512;
    localparam int INIT_DELAY = 1000;
    localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int POS_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [POS_W-1:0] SLOT_END    = POS_W'(SLOT_COUNT);
    localparam logic [15:0]      INIT_TICKS  = 16'(INIT_DELAY);
    localparam logic [7:0]       START_CODE  = 8'h00;

    localparam logic [1:0] EV_START   = 2'd0;
    localparam logic [1:0] EV_TIMEOUT = 2'd1;
    localparam logic [1:0] EV_SENT    = 2'd2;
    localparam logic [1:0] EV_WRITE   = 2'd3;

    localparam logic [3:0] ST_INIT       = 4'd0;
    localparam logic [3:0] ST_MBB        = 4'd1;
    localparam logic [3:0] ST_BREAK      = 4'd2;
    localparam logic [3:0] ST_MAB        = 4'd3;
    localparam logic [3:0] ST_START      = 4'd4;
    localparam logic [3:0] ST_START_MARK = 4'd5;
    localparam logic [3:0] ST_BYTE       = 4'd6;
    localparam logic [3:0] ST_MARK       = 4'd7;
    localparam logic [3:0] ST_END        = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_ACTION_LOCK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MBB         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BREAK       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAB         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IBM         = 3'd4;

    typedef struct packed {
        logic [1:0] func;
        logic [8:0] slot_index;
        logic [7:0] slot_value;
    } t_dfs_in;

    typedef struct packed {
        logic        timer_start;
        logic [15:0] timer_duration;
        logic        break_request;
        logic        byte_valid;
        logic [7:0]  byte_value;
        logic [3:0]  sequencer_state;
    } t_dfs_out;

    typedef struct packed {
        logic        action_lock;
        logic [15:0] mark_before_break_us;
        logic [15:0] break_length_us;
        logic [15:0] mark_after_break_us;
        logic [15:0] inter_byte_mark_us;
    } t_dfs_cfg;

    typedef struct packed {
        logic        timer_start;
        logic [15:0] timer_duration;
        logic        break_request;
        logic        byte_valid;
        logic        byte_from_slot;
        logic [3:0]  phase;
    } t_dfs_act;

endpackage

`default_nettype wire

FILE: rtl/dmx_frame_sequencer.sv
// Top level of the DMX512 frame sequencer: configuration, slot store and result pipeline.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_ready    i_in_data   (t_dfs_in)
//   out       output     o_out_valid / i_out_ready  o_out_data  (t_dfs_out)
//   cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One event is accepted per cycle while the slot store is not clearing and stage 1 can advance;
// its result is held in the stage 1 register, then in the output register.
// The single slot memory is read in the accept cycle of each event that sends a slot byte.
// After reset the slot memory is cleared one entry per cycle, all SLOT_COUNT (512) entries,
// and o_in_ready stays low until that pass ends; configuration writes are taken throughout.
// A stalled output holds one result and one more event can be accepted behind it.
`default_nettype none

module dmx_frame_sequencer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire dfs_pkg::t_dfs_in               i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output dfs_pkg::t_dfs_out                   o_out_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [dfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [dfs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dfs_pkg::*;

    t_dfs_cfg           r_cfg;
    logic               r_s1_valid;
    t_dfs_act           r_s1_act;
    logic               r_out_valid;
    t_dfs_out           r_out;

    logic               busy;
    logic               accept;
    logic               s1_adv;
    logic               in_ready;
    t_dfs_act           act;
    logic [SLOT_AW-1:0] rd_addr;
    logic [7:0]         rd_data;
    logic               wr_en;
    t_dfs_out           n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.action_lock          <= 1'b0;
            r_cfg.mark_before_break_us <= 16'd100;
            r_cfg.break_length_us      <= 16'd200;
            r_cfg.mark_after_break_us  <= 16'd20;
            r_cfg.inter_byte_mark_us   <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ACTION_LOCK: r_cfg.action_lock          <= i_cfg_data[0];
                REG_MBB:         r_cfg.mark_before_break_us <= i_cfg_data;
                REG_BREAK:       r_cfg.break_length_us      <= i_cfg_data;
                REG_MAB:         r_cfg.mark_after_break_us  <= i_cfg_data;
                REG_IBM:         r_cfg.inter_byte_mark_us   <= i_cfg_data;
                default:         r_cfg                      <= r_cfg;
            endcase
        end
    end

    assign s1_adv   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign in_ready = !busy && (!r_s1_valid || s1_adv);
    assign accept   = i_in_valid && in_ready;
    assign wr_en    = accept && (i_in_data.func == EV_WRITE)
                      && ({1'b0, i_in_data.slot_index} < SLOT_END);

    dfs_seq_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_func    (i_in_data.func),
        .i_cfg     (r_cfg),
        .o_act     (act),
        .o_rd_addr (rd_addr)
    );

    dfs_slot_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_in_data.slot_index[SLOT_AW-1:0]),
        .i_wr_data (i_in_data.slot_value),
        .i_rd_en   (accept && act.byte_from_slot),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .o_busy    (busy)
    );

    always_comb begin
        n_out.timer_start     = r_s1_act.timer_start;
        n_out.timer_duration  = r_s1_act.timer_duration;
        n_out.break_request   = r_s1_act.break_request;
        n_out.byte_valid      = r_s1_act.byte_valid;
        n_out.byte_value      = r_s1_act.byte_from_slot ? rd_data : START_CODE;
        n_out.sequencer_state = r_s1_act.phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_act <= act;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: rtl/dfs_slot_store.sv
// Slot level memory with a clearing pass after reset.
`default_nettype none

module dfs_slot_store (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr_en,
    input  wire logic [dfs_pkg::SLOT_AW-1:0] i_wr_addr,
    input  wire logic [7:0]                 i_wr_data,
    input  wire logic                       i_rd_en,
    input  wire logic [dfs_pkg::SLOT_AW-1:0] i_rd_addr,
    output logic      [7:0]                 o_rd_data,
    output logic                            o_busy
);
    import dfs_pkg::*;

    logic [7:0]         r_mem [SLOT_COUNT];
    logic [7:0]         r_rd_data;
    logic               r_busy;
    logic [SLOT_AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == SLOT_AW'(SLOT_COUNT - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= 8'h00;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

`default_nettype wire

FILE: rtl/dfs_seq_core.sv
// Sequencer phase and slot position registers with the event transition logic.
`default_nettype none

module dfs_seq_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [1:0]                 i_func,
    input  wire dfs_pkg::t_dfs_cfg          i_cfg,
    output dfs_pkg::t_dfs_act               o_act,
    output logic      [dfs_pkg::SLOT_AW-1:0] o_rd_addr
);
    import dfs_pkg::*;

    logic [3:0]       r_phase;
    logic [POS_W-1:0] r_pos;
    logic [3:0]       n_phase;
    logic [POS_W-1:0] n_pos;

    logic [3:0]       p1;
    logic [POS_W-1:0] pos1;
    logic [POS_W-1:0] pos_inc;
    logic             tmo;
    logic             sent;
    logic             act;
    logic             ibm_zero;
    t_dfs_act         a;

    always_comb begin
        tmo      = (i_func == EV_TIMEOUT);
        sent     = (i_func == EV_SENT);
        ibm_zero = (i_cfg.inter_byte_mark_us == 16'd0);
        pos_inc  = (r_pos < SLOT_END) ? r_pos + 1'b1 : r_pos;
        p1       = r_phase;
        pos1     = r_pos;
        unique case (r_phase)
            ST_INIT: begin
                if (tmo) p1 = ST_MBB;
            end
            ST_MBB: begin
                if (tmo) p1 = ST_BREAK;
            end
            ST_BREAK: begin
                if (tmo) p1 = ST_MAB;
            end
            ST_MAB: begin
                if (tmo) p1 = ST_START;
            end
            ST_START: begin
                if (sent) p1 = ibm_zero ? ST_BYTE : ST_START_MARK;
            end
            ST_START_MARK: begin
                if (tmo) p1 = ST_BYTE;
            end
            ST_BYTE: begin
                if (sent) begin
                    pos1 = pos_inc;
                    if (pos_inc >= SLOT_END) begin
                        p1 = ST_END;
                    end else begin
                        p1 = ibm_zero ? ST_BYTE : ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                if (tmo) p1 = (r_pos >= SLOT_END) ? ST_END : ST_BYTE;
            end
            default: begin
                p1 = r_phase;
            end
        endcase

        act     = (i_func == EV_START) || ((tmo || sent) && !i_cfg.action_lock);
        n_phase = (act && p1 == ST_END) ? ST_MBB : p1;
        n_pos   = (act && n_phase == ST_MBB) ? '0 : pos1;

        a       = '0;
        a.phase = n_phase;
        if (act) begin
            unique case (n_phase)
                ST_INIT: begin
                    a.timer_start    = 1'b1;
                    a.timer_duration = INIT_TICKS;
                end
                ST_MBB: begin
                    a.timer_start    = 1'b1;
                    a.timer_duration = i_cfg.mark_before_break_us;
                end
                ST_BREAK: begin
                    a.break_request  = 1'b1;
                    a.timer_start    = 1'b1;
                    a.timer_duration = i_cfg.break_length_us;
                end
                ST_MAB: begin
                    a.timer_start    = 1'b1;
                    a.timer_duration = i_cfg.mark_after_break_us;
                end
                ST_START: begin
                    a.byte_valid = 1'b1;
                end
                ST_START_MARK, ST_MARK: begin
                    a.timer_start    = 1'b1;
                    a.timer_duration = i_cfg.inter_byte_mark_us;
                end
                ST_BYTE: begin
                    a.byte_valid     = 1'b1;
                    a.byte_from_slot = (n_pos < SLOT_END);
                end
                default: begin
                    a.timer_start = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ST_INIT;
            r_pos   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
        end
    end

    assign o_act     = a;
    assign o_rd_addr = n_pos[SLOT_AW-1:0];

endmodule

`default_nettype wire

FILE: rtl/dfs_chk.sv
// Port-level checker for the DMX512 frame sequencer and its bind statement.
`default_nettype none

module dfs_chk (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    input  wire dfs_pkg::t_dfs_out              o_out_data
);
    import dfs_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled output transaction changed or dropped.");

    a_timer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.timer_start |-> o_out_data.timer_duration == 16'd0)
        else $error("Timer duration given without a timer start.");

    a_byte_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.byte_valid |->
            (o_out_data.sequencer_state == ST_START || o_out_data.sequencer_state == ST_BYTE))
        else $error("Byte sent outside the start code and slot states.");

    a_break_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.break_request |->
            (o_out_data.sequencer_state == ST_BREAK && o_out_data.timer_start))
        else $error("Break requested outside the break state or without its timer.");

endmodule

bind dmx_frame_sequencer dfs_chk u_dfs_chk (.*);

`default_nettype wire
